/* sv/mkd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mkd_pkg
// Shared widths, defaults, register indexes and the Morse letter table.
// ----------------------------------------------------------------------------
package mkd_pkg;

  localparam int unsigned GAP_W     = 4;
  localparam int unsigned LIMIT_W   = 10;
  localparam int unsigned PRESS_W   = 10;
  localparam int unsigned IDLE_W    = 12;
  localparam int unsigned BITS_W    = 4;
  localparam int unsigned COUNT_W   = 3;
  localparam int unsigned LETTER_W  = 5;
  localparam int unsigned ADDR_W    = 4;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned NUM_CODES = 26;

  localparam int unsigned MAX_SYMBOLS_DEF    = 4;
  localparam int unsigned WORD_LETTERS_DEF   = 4;
  localparam int unsigned TICKS_PER_UNIT_DEF = 400;

  localparam logic [GAP_W-1:0]   GAP_RESET   = 4'd10;
  localparam logic [LIMIT_W-1:0] SHORT_RESET = 10'd250;
  localparam logic [LIMIT_W-1:0] LONG_RESET  = 10'd700;

  localparam logic [PRESS_W-1:0] PRESS_MAX = '1;
  localparam logic [IDLE_W-1:0]  IDLE_MAX  = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Register indexes, taken from paddr[3:2].
  typedef enum logic [1:0] {
    REG_GAP_UNITS   = 2'd0,
    REG_SHORT_LIMIT = 2'd1,
    REG_LONG_LIMIT  = 2'd2,
    REG_NONE        = 2'd3
  } reg_index_t;

  typedef logic [COUNT_W-1:0]  code_len_t;
  typedef logic [BITS_W-1:0]   code_bits_t;
  typedef logic [LETTER_W-1:0] letter_t;

  // Symbol i of a letter is bit i, a one being a dash.
  localparam code_len_t CODE_LEN [NUM_CODES] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
    3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
  };
  localparam code_bits_t CODE_BITS [NUM_CODES] = '{
    4'd2, 4'd1, 4'd5, 4'd1, 4'd0, 4'd4, 4'd3, 4'd0, 4'd0, 4'd14, 4'd5, 4'd2, 4'd3,
    4'd1, 4'd7, 4'd6, 4'd11, 4'd2, 4'd0, 4'd1, 4'd4, 4'd8, 4'd6, 4'd9, 4'd13, 4'd3
  };

  // Returns the letter whose code matches, or NUM_CODES when none does.
  function automatic letter_t code_lookup(input code_len_t len, input code_bits_t bits);
    letter_t found;
    found = letter_t'(NUM_CODES);
    for (int k = NUM_CODES - 1; k >= 0; k--) begin
      if (CODE_LEN[k] == len && CODE_BITS[k] == bits) begin
        found = letter_t'(k);
      end
    end
    return found;
  endfunction

endpackage
`default_nettype wire

/* sv/morse_key_decoder.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// morse_key_decoder
// Straight-key Morse decoder: times key presses one tick per word, groups
// dots and dashes, and reports a letter or an error after a letter gap.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                   Payload
//  --------  ---------  --------------------------  ------------------------------
//  key       in         key_valid / key_stall       key_down
//  letter    out        letter_valid / letter_stall letter_index, is_error,
//                                                   word_full, letters_so_far
//  config    in         APB (psel, penable, pready)  gap_units, short_limit, long_limit
//
// One key word is taken every cycle. All the timing, classification and
// letter table match for a word is done in one pass of logic from the state
// registers into the state and the result register, so a letter decision
// appears on the letter channel in the cycle after the deciding key word.
// The result register frees itself as it is taken, so the key channel is
// stalled only while a result sits in that register and the letter channel
// itself is stalled. Reset is synchronous and restores the register defaults
// and clears all timing and letter state.
//
module morse_key_decoder #(
  parameter int unsigned MAX_SYMBOLS    = mkd_pkg::MAX_SYMBOLS_DEF,
  parameter int unsigned WORD_LETTERS   = mkd_pkg::WORD_LETTERS_DEF,
  parameter int unsigned TICKS_PER_UNIT = mkd_pkg::TICKS_PER_UNIT_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // key channel
  input  wire logic                           key_valid,
  output logic                                key_stall,
  input  wire logic                           key_down,
  // letter channel
  output logic                                letter_valid,
  input  wire logic                           letter_stall,
  output logic [mkd_pkg::LETTER_W-1:0]        letter_index,
  output logic                                is_error,
  output logic                                word_full,
  output logic [mkd_pkg::COUNT_W-1:0]         letters_so_far,
  // configuration port
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [mkd_pkg::ADDR_W-1:0]     paddr,
  input  wire logic [mkd_pkg::DATA_W-1:0]     pwdata,
  output logic [mkd_pkg::DATA_W-1:0]          prdata,
  output logic                                pready
);

  // The gap timeout reaches TICKS_PER_UNIT times the largest gap_units value.
  localparam int unsigned RANGE_W = $clog2(TICKS_PER_UNIT * ((1 << mkd_pkg::GAP_W) - 1) + 1);
  localparam int unsigned CMP_W   = (RANGE_W > mkd_pkg::IDLE_W) ? RANGE_W : mkd_pkg::IDLE_W;
  localparam logic [mkd_pkg::COUNT_W-1:0] SYM_LIMIT  = mkd_pkg::COUNT_W'(MAX_SYMBOLS);
  localparam logic [mkd_pkg::COUNT_W-1:0] BITS_LIMIT = mkd_pkg::COUNT_W'(mkd_pkg::BITS_W);
  localparam logic [mkd_pkg::COUNT_W:0]   WORD_LIMIT = (mkd_pkg::COUNT_W + 1)'(WORD_LETTERS);

  // Configuration registers.
  logic [mkd_pkg::GAP_W-1:0]   gap_units;
  logic [mkd_pkg::LIMIT_W-1:0] short_limit;
  logic [mkd_pkg::LIMIT_W-1:0] long_limit;

  // Timing and letter state.
  logic [mkd_pkg::PRESS_W-1:0] press_ticks, press_ticks_next;
  logic [mkd_pkg::IDLE_W-1:0]  idle_ticks, idle_ticks_next;
  logic                        key_was_down, key_was_down_next;
  logic                        letter_started, letter_started_next;
  logic [mkd_pkg::BITS_W-1:0]  symbol_bits, symbol_bits_next;
  logic [mkd_pkg::COUNT_W-1:0] symbol_count, symbol_count_next;
  logic                        group_bad, group_bad_next;
  logic [mkd_pkg::COUNT_W-1:0] letter_count, letter_count_next;
  logic                        word_waiting, word_waiting_next;

  // Combinational working signals.
  logic                        key_fire;
  logic                        cfg_write;
  mkd_pkg::reg_index_t         reg_index;
  logic [mkd_pkg::IDLE_W-1:0]  idle_inc;
  logic [RANGE_W-1:0]          gap_range;
  logic                        is_dash;
  logic                        is_bad;
  logic [mkd_pkg::BITS_W-1:0]  bits_app;
  logic [mkd_pkg::COUNT_W-1:0] count_app;
  logic                        bad_app;
  logic                        do_append;
  logic                        decide;
  logic                        match_ok;
  mkd_pkg::letter_t            found;
  logic                        err;
  logic [mkd_pkg::COUNT_W-1:0] count_after;
  logic                        full_after;
  logic                        emit;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_index = mkd_pkg::reg_index_t'(paddr[3:2]);

  // The result register is emptied in the same cycle it is taken, so only a
  // held result blocks new key words.
  assign key_stall = letter_valid && letter_stall;
  assign key_fire  = key_valid && !key_stall;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      gap_units   <= mkd_pkg::GAP_RESET;
      short_limit <= mkd_pkg::SHORT_RESET;
      long_limit  <= mkd_pkg::LONG_RESET;
    end else if (cfg_write) begin
      case (reg_index)
        mkd_pkg::REG_GAP_UNITS:   gap_units   <= pwdata[mkd_pkg::GAP_W-1:0];
        mkd_pkg::REG_SHORT_LIMIT: short_limit <= pwdata[mkd_pkg::LIMIT_W-1:0];
        mkd_pkg::REG_LONG_LIMIT:  long_limit  <= pwdata[mkd_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    case (reg_index)
      mkd_pkg::REG_GAP_UNITS:   prdata = mkd_pkg::DATA_W'(gap_units);
      mkd_pkg::REG_SHORT_LIMIT: prdata = mkd_pkg::DATA_W'(short_limit);
      mkd_pkg::REG_LONG_LIMIT:  prdata = mkd_pkg::DATA_W'(long_limit);
      default:                  prdata = '0;
    endcase
  end

  // The gap timeout is a small constant times a four-bit value.
  assign gap_range = RANGE_W'(TICKS_PER_UNIT * gap_units);

  // Idle count as it stands after a released tick, saturating at the top.
  assign idle_inc = (idle_ticks == mkd_pkg::IDLE_MAX) ? idle_ticks : idle_ticks + 1'b1;

  // Classify the press that has just ended. Only the first four symbols are
  // stored; the count carries on one past the limit to flag a long group.
  always_comb begin
    is_dash   = (press_ticks >= short_limit) && (press_ticks <= long_limit);
    is_bad    = (press_ticks >= short_limit) && (press_ticks > long_limit);
    bits_app  = symbol_bits;
    if (symbol_count < BITS_LIMIT && is_dash) begin
      bits_app[symbol_count[1:0]] = 1'b1;
    end
    count_app = symbol_count;
    if (symbol_count <= SYM_LIMIT && symbol_count < mkd_pkg::COUNT_MAX) begin
      count_app = symbol_count + 1'b1;
    end
    bad_app   = group_bad || is_bad;
  end

  // A released tick ends a press when the key was down on the word before.
  assign do_append = key_was_down && letter_started;

  // Letter decision on a released tick once the gap has run out.
  always_comb begin
    logic [mkd_pkg::BITS_W-1:0]  grp_bits;
    logic [mkd_pkg::COUNT_W-1:0] grp_count;
    logic                        grp_bad;
    grp_bits  = do_append ? bits_app  : symbol_bits;
    grp_count = do_append ? count_app : symbol_count;
    grp_bad   = do_append ? bad_app   : group_bad;
    decide    = !word_waiting && !key_down && letter_started &&
                (CMP_W'(idle_inc) >= CMP_W'(gap_range));
    match_ok  = !grp_bad && (grp_count <= SYM_LIMIT) &&
                (CMP_W'(idle_inc) <= CMP_W'(gap_range));
    found     = match_ok ? mkd_pkg::code_lookup(grp_count, grp_bits)
                         : mkd_pkg::letter_t'(mkd_pkg::NUM_CODES);
    err       = (found >= mkd_pkg::letter_t'(mkd_pkg::NUM_CODES));
    count_after = letter_count;
    if (!err && letter_count < mkd_pkg::COUNT_MAX) begin
      count_after = letter_count + 1'b1;
    end
    full_after = !err && ({1'b0, count_after} >= WORD_LIMIT);
  end

  assign emit = key_fire && decide;

  // Next state for one accepted key word.
  always_comb begin
    press_ticks_next    = press_ticks;
    idle_ticks_next     = idle_ticks;
    key_was_down_next   = key_was_down;
    letter_started_next = letter_started;
    symbol_bits_next    = symbol_bits;
    symbol_count_next   = symbol_count;
    group_bad_next      = group_bad;
    letter_count_next   = letter_count;
    word_waiting_next   = word_waiting;
    if (key_fire) begin
      if (word_waiting) begin
        // A full word is held until the key goes down; that tick is not timed.
        if (key_down) begin
          letter_count_next = '0;
          word_waiting_next = 1'b0;
          key_was_down_next = 1'b0;
          press_ticks_next  = '0;
        end
      end else if (key_down) begin
        if (press_ticks != mkd_pkg::PRESS_MAX) begin
          press_ticks_next = press_ticks + 1'b1;
        end
        idle_ticks_next     = '0;
        key_was_down_next   = 1'b1;
        letter_started_next = 1'b1;
      end else begin
        if (do_append) begin
          symbol_bits_next  = bits_app;
          symbol_count_next = count_app;
          group_bad_next    = bad_app;
        end
        key_was_down_next = 1'b0;
        press_ticks_next  = '0;
        idle_ticks_next   = idle_inc;
        if (decide) begin
          letter_count_next   = count_after;
          word_waiting_next   = full_after;
          symbol_bits_next    = '0;
          symbol_count_next   = '0;
          group_bad_next      = 1'b0;
          letter_started_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      press_ticks    <= '0;
      idle_ticks     <= '0;
      key_was_down   <= 1'b0;
      letter_started <= 1'b0;
      symbol_bits    <= '0;
      symbol_count   <= '0;
      group_bad      <= 1'b0;
      letter_count   <= '0;
      word_waiting   <= 1'b0;
    end else begin
      press_ticks    <= press_ticks_next;
      idle_ticks     <= idle_ticks_next;
      key_was_down   <= key_was_down_next;
      letter_started <= letter_started_next;
      symbol_bits    <= symbol_bits_next;
      symbol_count   <= symbol_count_next;
      group_bad      <= group_bad_next;
      letter_count   <= letter_count_next;
      word_waiting   <= word_waiting_next;
    end
  end

  // Result register: refilled by a decision, emptied when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      letter_valid <= 1'b0;
    end else begin
      letter_valid <= emit || (letter_valid && letter_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      letter_index   <= err ? '0 : found;
      is_error       <= err;
      word_full      <= full_after;
      letters_so_far <= count_after;
    end
  end

`ifndef SYNTHESIS
  // A press in progress always belongs to a started letter.
  a_press_in_letter: assert property (@(posedge clk) disable iff (rst)
    key_was_down |-> letter_started)
    else $error("key held down outside a started letter");

  // A full word only waits once enough letters have been counted.
  a_wait_count: assert property (@(posedge clk) disable iff (rst)
    word_waiting |-> ({1'b0, letter_count} >= WORD_LIMIT))
    else $error("word waiting with too few letters");

  // An error result carries letter index zero and never marks a full word.
  a_error_index: assert property (@(posedge clk) disable iff (rst)
    (letter_valid && is_error) |-> (letter_index == '0 && !word_full))
    else $error("error result with a letter or a full word");

  // A good letter is a real letter and has been counted.
  a_good_letter: assert property (@(posedge clk) disable iff (rst)
    (letter_valid && !is_error) |->
      (letter_index < mkd_pkg::letter_t'(mkd_pkg::NUM_CODES) && letters_so_far != '0))
    else $error("good letter out of range or uncounted");

  // The symbol count never runs past one beyond the group limit.
  a_symbol_count: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, symbol_count} <= ({1'b0, SYM_LIMIT} + 1'b1)))
    else $error("symbol count past its limit");
`endif

endmodule
`default_nettype wire
